// File: rtl/assert_macros.svh
// Assertion macros shared by the pixel color pipeline RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// a implies c in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: implication");
// a implies c a fixed number of cycles later
`define ASSERT_DELAY(lbl, clk, rst, a, n, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (c)) \
    else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPL(lbl, clk, rst, a, c)
`define ASSERT_DELAY(lbl, clk, rst, a, n, c)
`endif
`endif

// File: rtl/lpc_pkg.sv
// Types and constants of the LED pixel color pipeline.
// No dependencies; used by lpc_lane and led_pixel_color_pipeline_core.
package lpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COLOR_MODE = 3'd0;
  localparam logic [2:0] REG_ORDER_CODE = 3'd1;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [2:0] REG_CORR_EN    = 3'd3;
  localparam logic [2:0] REG_GAIN_RED   = 3'd4;
  localparam logic [2:0] REG_GAIN_GREEN = 3'd5;
  localparam logic [2:0] REG_GAIN_BLUE  = 3'd6;

  // color modes
  localparam logic [2:0] MODE_RGB          = 3'd1;
  localparam logic [2:0] MODE_RGBW_ACCURATE = 3'd2;
  localparam logic [2:0] MODE_RGBW_BRIGHTER = 3'd3;
  localparam logic [2:0] MODE_RGBW_RGBONLY  = 3'd4;

  localparam logic [4:0] ORDER_LAST_RGB  = 5'd6;
  localparam logic [4:0] ORDER_LAST_RGBW = 5'd24;
  localparam int         ORDER_ROWS      = 25;

  // per-lane scaling controls
  typedef struct packed {
    logic       corr;
    logic [7:0] gain;
    logic [6:0] pct;
    logic       bri_zero;
  } lpc_lane_cfg_t;

  // slot k takes channel ORDER_TABLE[code][k]; 0 R, 1 G, 2 B, 3 W
  localparam logic [1:0] ORDER_TABLE [ORDER_ROWS][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
    '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd3, 2'd2, 2'd0, 2'd1}
  };

endpackage

// File: rtl/lpc_lane.sv
// One channel of the pixel pipeline: gain, divide by 255, brightness percent,
// divide by 100. Four register stages. Depends on lpc_pkg.
module lpc_lane (
  input  logic                  clk,
  input  lpc_pkg::lpc_lane_cfg_t cfg,
  input  logic [7:0]            cin,
  output logic [7:0]            cout
);
  import lpc_pkg::*;

  logic [15:0] prod;
  logic [16:0] div_sum;
  logic [7:0]  quot;
  logic        byp;
  logic [14:0] bmul;
  logic        byp_next;
  logic [14:0] bmul_next;
  logic [30:0] recip;

  // stage A: gain product; without correction the gain is 255, which
  // divides back out exactly
  always_ff @(posedge clk) begin
    prod <= {8'd0, (cfg.corr ? cfg.gain : 8'd255)} * {8'd0, cin};
  end

  // floor(p/255) for p up to 255*255: (p + 1 + (p >> 8)) >> 8
  assign div_sum = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};

  always_ff @(posedge clk) begin
    quot <= div_sum[15:8];
  end

  // stage C: brightness percent; zero value or zero brightness passes through
  always_comb begin
    byp_next  = (quot == 8'd0) || cfg.bri_zero;
    bmul_next = byp_next ? {7'd0, quot} : {7'd0, quot} * {8'd0, cfg.pct};
  end

  always_ff @(posedge clk) begin
    byp  <= byp_next;
    bmul <= bmul_next;
  end

  // floor(m/100) as (m * 41944) >> 22, exact for m below 43690
  assign recip = {16'd0, bmul} * 31'd41944;

  always_ff @(posedge clk) begin
    cout <= byp ? bmul[7:0] : recip[29:22];
  end

endmodule

// File: rtl/led_pixel_color_pipeline_core.sv
// LED pixel color pipeline: one pixel per cycle sustained, busy is always low.
// Stages: white extraction, then four per-channel stages (gain multiply,
// divide by 255, brightness multiply, divide by 100), then channel ordering.
// Results cannot be stalled. Synchronous reset clears the valid bits and
// returns the configuration registers to their reset values.
module led_pixel_color_pipeline_core #(
  parameter int INDEX_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] led_index,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output logic                  done,
  output logic [INDEX_BITS-1:0] led_index_out,
  output logic [7:0]            slot0,
  output logic [7:0]            slot1,
  output logic [7:0]            slot2,
  output logic [7:0]            slot3,
  output logic                  four_channel
);
  import lpc_pkg::*;

  localparam int LANE_STAGES = 4;

  // configuration
  logic [2:0] color_mode;
  logic [4:0] order_code;
  logic [6:0] pct;
  logic       bri_zero;
  logic       corr_en;
  logic [7:0] gain_red;
  logic [7:0] gain_green;
  logic [7:0] gain_blue;

  logic [14:0] pct_mul;
  logic [15:0] pct_sum;

  // brightness is kept as its percent, floor(bri*100/255)
  assign pct_mul = {7'd0, cfg_data} * 15'd100;
  assign pct_sum = {1'b0, pct_mul} + 16'd1 + {9'd0, pct_mul[14:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_RGB;
      order_code <= 5'd0;
      pct        <= 7'd100;
      bri_zero   <= 1'b0;
      corr_en    <= 1'b0;
      gain_red   <= 8'd255;
      gain_green <= 8'd255;
      gain_blue  <= 8'd255;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLOR_MODE: color_mode <= cfg_data[2:0];
        REG_ORDER_CODE: order_code <= cfg_data[4:0];
        REG_BRIGHTNESS: begin
          pct      <= pct_sum[14:8];
          bri_zero <= (cfg_data == 8'd0);
        end
        REG_CORR_EN:    corr_en    <= cfg_data[0];
        REG_GAIN_RED:   gain_red   <= cfg_data;
        REG_GAIN_GREEN: gain_green <= cfg_data;
        REG_GAIN_BLUE:  gain_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: white extraction
  logic       rgbw_in;
  logic [7:0] min_rg;
  logic [7:0] white;
  logic [7:0] r_next, g_next, b_next, w_next;

  always_comb begin
    rgbw_in = color_mode inside {MODE_RGBW_ACCURATE, MODE_RGBW_BRIGHTER,
                                 MODE_RGBW_RGBONLY};
    min_rg  = (red_in < green_in) ? red_in : green_in;
    white   = (blue_in < min_rg) ? blue_in : min_rg;
    r_next  = red_in;
    g_next  = green_in;
    b_next  = blue_in;
    w_next  = 8'd0;
    if (rgbw_in) begin
      case (color_mode)
        MODE_RGBW_ACCURATE: begin
          r_next = red_in - white;
          g_next = green_in - white;
          b_next = blue_in - white;
          w_next = white;
        end
        MODE_RGBW_RGBONLY: w_next = 8'd0;
        default:           w_next = white;
      endcase
    end
  end

  logic                  vld1;
  logic                  rgbw1;
  logic [INDEX_BITS-1:0] idx1;
  logic [7:0]            ch1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rgbw1  <= rgbw_in;
    idx1   <= led_index;
    ch1[0] <= r_next;
    ch1[1] <= g_next;
    ch1[2] <= b_next;
    ch1[3] <= w_next;
  end

  // per-channel scaling lanes; white gets no gain correction
  lpc_lane_cfg_t lane_cfg [4];
  logic [7:0]    ch5 [4];

  always_comb begin
    lane_cfg[0] = '{corr: corr_en, gain: gain_red,   pct: pct, bri_zero: bri_zero};
    lane_cfg[1] = '{corr: corr_en, gain: gain_green, pct: pct, bri_zero: bri_zero};
    lane_cfg[2] = '{corr: corr_en, gain: gain_blue,  pct: pct, bri_zero: bri_zero};
    lane_cfg[3] = '{corr: 1'b0,    gain: 8'd255,     pct: pct, bri_zero: bri_zero};
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    lpc_lane u_lane (
      .clk  (clk),
      .cfg  (lane_cfg[k]),
      .cin  (ch1[k]),
      .cout (ch5[k])
    );
  end

  // side band delay line matching the lanes
  logic                  vld_d  [LANE_STAGES];
  logic                  rgbw_d [LANE_STAGES];
  logic [INDEX_BITS-1:0] idx_d  [LANE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_STAGES; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else begin
      vld_d[0] <= vld1;
      for (int i = 1; i < LANE_STAGES; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rgbw_d[0] <= rgbw1;
    idx_d[0]  <= idx1;
    for (int i = 1; i < LANE_STAGES; i++) begin
      rgbw_d[i] <= rgbw_d[i-1];
      idx_d[i]  <= idx_d[i-1];
    end
  end

  // stage 6: channel order and output register
  logic       rgbw5;
  logic [4:0] code;
  logic [7:0] ordered [4];

  always_comb begin
    rgbw5 = rgbw_d[LANE_STAGES-1];
    if (rgbw5) begin
      code = (order_code > ORDER_LAST_RGBW) ? 5'd0 : order_code;
    end else begin
      code = (order_code > ORDER_LAST_RGB) ? 5'd0 : order_code;
    end
    for (int k = 0; k < 4; k++) begin
      ordered[k] = ch5[ORDER_TABLE[code][k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_d[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    led_index_out <= idx_d[LANE_STAGES-1];
    slot0         <= ordered[0];
    slot1         <= ordered[1];
    slot2         <= ordered[2];
    slot3         <= ordered[3];
    four_channel  <= rgbw5;
  end

`include "assert_macros.svh"

  `ASSERT_DELAY(a_latency, clk, rst, accept, 6, done)
  `ASSERT_IMPL(a_done_has_source, clk, rst, done, $past(accept, 6))
  `ASSERT_IMPL(a_rgb_no_white, clk, rst, done && !four_channel, slot3 == 8'd0)

endmodule
